FILE: sv/pia_pkg.sv
// pia_pkg: shared types and codes for the pool index allocator.
// Holds the controller state enum, request and status codes, and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pia_pkg;

	localparam int unsigned INDEX_W = 8;
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned INDEX_REACH = 256;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_REJECTED  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_POP  = 2'd2
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;  // latch the request fields
		logic exec;     // carry out the latched request
		logic finish;   // deliver the popped index
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pop;      // latched request pops the free stack
	} dp_status_t;

endpackage
`default_nettype wire

FILE: sv/pia_ctrl.sv
// pia_ctrl: request sequencer of the pool index allocator.
// Steps capture, execute and (for a stack pop) delivery of the registered stack read.
// Depends on pia_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pia_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire pia_pkg::dp_status_t dp_sts,
	output pia_pkg::cmd_t          cmd,
	output logic                   busy
);
	import pia_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = dp_sts.pop ? S_POP : S_IDLE;
			end
			S_POP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				cmd.capture = start;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
			end
			S_POP: begin
				cmd.finish = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: sv/pia_datapath.sv
// pia_datapath: free stack memory, counters, pool size register and result registers.
// Driven by pia_ctrl commands. Depends on pia_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pia_datapath #(
	parameter int unsigned STACK_DEPTH = 256
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire pia_pkg::cmd_t                     cmd,
	output pia_pkg::dp_status_t                    dp_sts,
	input  wire logic                              operation,
	input  wire logic [pia_pkg::INDEX_W-1:0]       slot_index,
	input  wire logic                              cfg_wr_en,
	input  wire logic [pia_pkg::COUNT_W-1:0]       cfg_wr_data,
	output logic                                   done,
	output logic [pia_pkg::INDEX_W-1:0]            granted_index,
	output logic [pia_pkg::STATUS_W-1:0]           status
);
	import pia_pkg::*;

	localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [COUNT_W-1:0] CAP = COUNT_W'(STACK_DEPTH);

	logic [INDEX_W-1:0] stack_mem [STACK_DEPTH];
	logic [INDEX_W-1:0] rd_data_q;

	logic [COUNT_W-1:0] pool_entries_q;
	logic [COUNT_W-1:0] free_count_q;
	logic [COUNT_W-1:0] high_water_q;
	op_t                op_q;
	logic [INDEX_W-1:0] slot_q;
	logic               done_q;
	logic [INDEX_W-1:0] granted_q;
	status_t            status_q;

	logic [COUNT_W-1:0] lim;
	logic [COUNT_W-1:0] pop_count;
	logic               do_pop;
	logic               do_bump;
	logic               do_push;
	logic               free_bad;

	// effective size: register clamped to the stack depth
	assign lim = (pool_entries_q > CAP) ? CAP : pool_entries_q;
	assign pop_count = free_count_q - COUNT_W'(1);
	assign free_bad = ({1'b0, slot_q} >= lim) || (free_count_q >= lim);
	assign do_pop = (op_q == OP_ALLOC) && (free_count_q != '0);
	assign do_bump = (op_q == OP_ALLOC) && !do_pop && (high_water_q < lim);
	assign do_push = (op_q == OP_FREE) && !free_bad;
	assign dp_sts.pop = do_pop;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= op_t'(operation);
			slot_q <= slot_index;
		end
		if (cmd.exec && do_push) begin
			stack_mem[free_count_q[ADDR_W-1:0]] <= slot_q;
		end
		if (cmd.exec && do_pop) begin
			rd_data_q <= stack_mem[pop_count[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_entries_q <= COUNT_W'(INDEX_REACH);
			free_count_q <= '0;
			high_water_q <= '0;
			done_q <= 1'b0;
			granted_q <= '0;
			status_q <= ST_OK;
		end else begin
			done_q <= (cmd.exec && !do_pop) || cmd.finish;
			if (cfg_wr_en) begin
				pool_entries_q <= cfg_wr_data;
			end
			if (cmd.exec) begin
				if (do_pop) begin
					free_count_q <= pop_count;
				end else if (op_q == OP_ALLOC) begin
					if (do_bump) begin
						granted_q <= high_water_q[INDEX_W-1:0];
						status_q <= ST_OK;
						high_water_q <= high_water_q + COUNT_W'(1);
					end else begin
						granted_q <= '0;
						status_q <= ST_EXHAUSTED;
					end
				end else if (do_push) begin
					granted_q <= '0;
					status_q <= ST_OK;
					free_count_q <= free_count_q + COUNT_W'(1);
				end else begin
					granted_q <= '0;
					status_q <= ST_REJECTED;
				end
			end else if (cmd.finish) begin
				granted_q <= rd_data_q;
				status_q <= ST_OK;
			end
		end
	end

	assign done = done_q;
	assign granted_index = granted_q;
	assign status = status_q;

endmodule
`default_nettype wire

FILE: sv/pool_index_allocator.sv
// pool_index_allocator: top level of the fixed pool slot allocator.
// Joins pia_ctrl and pia_datapath; depends on pia_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Raise start with operation and slot_index while busy is low to issue a
// request: allocate pops the most recently freed slot from a LIFO free
// stack, or else takes the next never-used slot while it lies below the
// pool size; free pushes slot_index back, or is rejected if it lies at or
// past the pool size or the stack is full. Each request yields exactly one
// result, shown on granted_index and status for the single cycle in which
// done is high; the receiver cannot stall it, so capture it then. Free and
// high-water allocates finish with the execute state; a stack allocate adds
// a pop state for the registered read of the stack memory. busy drops in
// the cycle done rises, so a new request may be issued alongside a result.
// Write pool_entries through cfg_wr_en and cfg_wr_data only while idle; it
// is clamped to the stack depth.
module pool_index_allocator #(
	parameter int unsigned POOL_SIZE = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        operation,
	input  wire logic [pia_pkg::INDEX_W-1:0] slot_index,
	input  wire logic                        cfg_wr_en,
	input  wire logic [pia_pkg::COUNT_W-1:0] cfg_wr_data,
	output logic                             done,
	output logic [pia_pkg::INDEX_W-1:0]      granted_index,
	output logic [pia_pkg::STATUS_W-1:0]     status
);
	import pia_pkg::*;

	// an 8-bit index cannot reach past INDEX_REACH slots
	localparam int unsigned STACK_DEPTH =
		(POOL_SIZE < INDEX_REACH) ? POOL_SIZE : INDEX_REACH;

	cmd_t       cmd;
	dp_status_t dp_sts;

	pia_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.dp_sts (dp_sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	pia_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.dp_sts        (dp_sts),
		.operation     (operation),
		.slot_index    (slot_index),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.done          (done),
		.granted_index (granted_index),
		.status        (status)
	);

endmodule
`default_nettype wire
